/* rtl/core/idr_pkg.sv */
// Package: item types, result codes and character helpers for the include directive recogniser.
`timescale 1ns / 1ps

package idr_pkg;

  // Result kinds
  localparam logic [1:0] KIND_NAME   = 2'd0;
  localparam logic [1:0] KIND_FOUND  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [3:0] INC_LEN  = 4'd7;
  localparam logic [3:0] BIN_LEN  = 4'd6;
  localparam logic [3:0] WLEN_MAX = 4'd15;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] name_byte;
    logic       parse_flag;
  } out_item_t;

  // Result of one scan step
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } scan_res_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
  endfunction

  // Letters of "include" by position
  function automatic logic [7:0] inc_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h69; // i
      3'd1:    ch = 8'h6E; // n
      3'd2:    ch = 8'h63; // c
      3'd3:    ch = 8'h6C; // l
      3'd4:    ch = 8'h75; // u
      3'd5:    ch = 8'h64; // d
      3'd6:    ch = 8'h65; // e
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Letters of "incbin" by position
  function automatic logic [7:0] bin_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h69; // i
      3'd1:    ch = 8'h6E; // n
      3'd2:    ch = 8'h63; // c
      3'd3:    ch = 8'h62; // b
      3'd4:    ch = 8'h69; // i
      3'd5:    ch = 8'h6E; // n
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/core/idr_scan.sv */
// Line scanner: phase machine and word match state, one item per step.
`timescale 1ns / 1ps

module idr_scan
  import idr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  logic      syntax_mode,
  output scan_res_t res
);

  typedef enum logic [5:0] {
    PH_START = 6'b000001,
    PH_LEAD  = 6'b000010,
    PH_WORD  = 6'b000100,
    PH_GAP   = 6'b001000,
    PH_NAME  = 6'b010000,
    PH_DEAD  = 6'b100000
  } phase_t;

  phase_t     phase_r,   phase_nxt;
  logic [3:0] wlen_r,    wlen_nxt;
  logic       inc_ok_r,  inc_ok_nxt;
  logic       bin_ok_r,  bin_ok_nxt;
  logic       given_r,   given_nxt;

  logic [7:0] c;
  logic [7:0] lc;
  logic       take_inc_ok;
  logic       take_bin_ok;
  logic       take;

  assign c  = item.char_code;
  assign lc = to_lower(c);
  // Would the character keep each candidate word alive?
  assign take_inc_ok = (wlen_r < INC_LEN) && (inc_char(wlen_r[2:0]) == lc);
  assign take_bin_ok = (wlen_r < BIN_LEN) && (bin_char(wlen_r[2:0]) == lc);

  always_comb begin
    phase_nxt  = phase_r;
    wlen_nxt   = wlen_r;
    inc_ok_nxt = inc_ok_r;
    bin_ok_nxt = bin_ok_r;
    given_nxt  = given_r;
    take       = 1'b0;
    res        = '0;

    if (item.line_end) begin
      res.valid      = !given_r;
      res.item.kind  = KIND_REJECT;
      phase_nxt      = PH_START;
      wlen_nxt       = '0;
      inc_ok_nxt     = 1'b1;
      bin_ok_nxt     = 1'b1;
      given_nxt      = 1'b0;
    end else begin
      case (phase_r)
        PH_START: begin
          if (is_blank(c)) begin
            phase_nxt = PH_LEAD;
          end else if (((c == CH_UNDER) || is_letter(c)) && !syntax_mode) begin
            take      = 1'b1;
            phase_nxt = PH_WORD;
          end else begin
            phase_nxt = PH_DEAD;
          end
        end
        PH_LEAD: begin
          if (is_blank(c)) begin
            phase_nxt = PH_LEAD;
          end else if ((c == CH_UNDER) || is_letter(c)) begin
            take      = 1'b1;
            phase_nxt = PH_WORD;
          end else begin
            phase_nxt = PH_DEAD;
          end
        end
        PH_WORD: begin
          if (is_letter(c) || is_digit(c)) begin
            take = 1'b1;
          end else if (is_blank(c)) begin
            if (inc_ok_r && (wlen_r == INC_LEN)) begin
              bin_ok_nxt = 1'b0;
              phase_nxt  = PH_GAP;
            end else if (syntax_mode && bin_ok_r && (wlen_r == BIN_LEN)) begin
              inc_ok_nxt = 1'b0;
              phase_nxt  = PH_GAP;
            end else begin
              phase_nxt = PH_DEAD;
            end
          end else begin
            phase_nxt = PH_DEAD;
          end
        end
        PH_GAP: begin
          if (is_blank(c)) begin
            phase_nxt = PH_GAP;
          end else if (c == CH_QUOTE) begin
            phase_nxt = PH_NAME;
          end else begin
            phase_nxt = PH_DEAD;
          end
        end
        PH_NAME: begin
          res.valid = 1'b1;
          if (c == CH_QUOTE) begin
            res.item.kind       = KIND_FOUND;
            res.item.parse_flag = inc_ok_r;
            given_nxt           = 1'b1;
            phase_nxt           = PH_DEAD;
          end else begin
            res.item.kind      = KIND_NAME;
            res.item.name_byte = c;
          end
        end
        default: begin
          phase_nxt = PH_DEAD;
        end
      endcase

      if (take) begin
        inc_ok_nxt = inc_ok_r & take_inc_ok;
        bin_ok_nxt = bin_ok_r & take_bin_ok;
        if (wlen_r < WLEN_MAX) begin
          wlen_nxt = wlen_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      wlen_r   <= '0;
      inc_ok_r <= 1'b1;
      bin_ok_r <= 1'b1;
      given_r  <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      wlen_r   <= wlen_nxt;
      inc_ok_r <= inc_ok_nxt;
      bin_ok_r <= bin_ok_nxt;
      given_r  <= given_nxt;
    end
  end

endmodule

/* rtl/core/include_directive_recognizer.sv */
// Top level: input register, line scanner and result register of the recogniser.
//
// Usage: feed one source-line byte per item on the in_ channel (char_code, or
// line_end set to close the line). The out_ channel returns a name byte for
// each byte between the double quotes of an include directive, then a found
// item with parse_flag (1 include, 0 incbin) at the closing quote; a line
// that is not a directive returns one rejected item at its line end, and the
// receiver drops the name bytes it collected for that line.
// Write syntax_mode on the cfg_ channel only while the block is idle; cfg_ready
// is always high.
// Timing: an item accepted at an edge sits in the input register, is scanned
// there combinationally and, if it causes a result, lands in the result register
// at an edge on which that register is free. One item is taken every cycle
// while the result register is empty or being drained.
// Reset: rst_n low clears both registers' valid flags, puts the scanner at
// line start and sets syntax_mode to 0.
// Stall: while out_ready is low and a result waits, the input register holds
// its item; in_ready stays high as long as that register is empty.
`timescale 1ns / 1ps

module include_directive_recognizer
  import idr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  // input channel
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  // result channel
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  // configuration channel
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic      mode_r;
  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  logic      out_free;
  logic      step;
  scan_res_t res;

  // The result register can load when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;
  // Advance the held item through the scanner when its result has a place
  assign step     = in_valid_r && out_free;
  assign in_ready = !in_valid_r || out_free;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  idr_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (in_item_r),
    .syntax_mode (mode_r),
    .res         (res)
  );

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  // Input register: refill whenever it empties or its item advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_item_r <= res.item;
    end
  end

endmodule

/* tb/idr_check_pkg.sv */
// Scan model and result scoreboard used by the include directive recogniser testbench.
`timescale 1ns / 1ps

package idr_check_pkg;
  import idr_pkg::*;

  typedef enum logic [2:0] {
    SCAN_START,
    SCAN_LEAD,
    SCAN_WORD,
    SCAN_GAP,
    SCAN_NAME,
    SCAN_DONE
  } scan_phase_t;

  class directive_scoreboard;
    bit          incbin_mode;
    scan_phase_t phase;
    logic [3:0]  word_len;
    bit          include_ok;
    bit          incbin_ok;
    bit          verdict_given;
    string       include_word;
    string       incbin_word;
    out_item_t   pending_results[$];
    int unsigned errors;
    int unsigned names_seen;
    int unsigned found_seen;
    int unsigned rejects_seen;

    function new();
      include_word = "include";
      incbin_word  = "incbin";
      incbin_mode  = 1'b0;
      errors       = 0;
      names_seen   = 0;
      found_seen   = 0;
      rejects_seen = 0;
      restart_line();
    endfunction

    function void restart_line();
      phase         = SCAN_START;
      word_len      = '0;
      include_ok    = 1'b1;
      incbin_ok     = 1'b1;
      verdict_given = 1'b0;
    endfunction

    function void set_mode(bit m);
      incbin_mode = m;
    endfunction

    function bit blank_char(logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB};
    endfunction

    function bit alpha_char(logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function bit num_char(logic [7:0] c);
      return c inside {[8'h30:8'h39]};
    endfunction

    // Fold one word character into both keyword matches.
    function void take_letter(logic [7:0] c);
      logic [7:0] lc;
      lc = (c inside {[8'h41:8'h5A]}) ? (c | 8'h20) : c;
      if (word_len >= INC_LEN || lc != 8'(include_word[word_len]))
        include_ok = 1'b0;
      if (word_len >= BIN_LEN || lc != 8'(incbin_word[word_len]))
        incbin_ok = 1'b0;
      if (word_len != WLEN_MAX)
        word_len++;
    endfunction

    function void queue_result(logic [1:0] k, logic [7:0] b, logic f);
      out_item_t r;
      r.kind       = k;
      r.name_byte  = b;
      r.parse_flag = f;
      pending_results.push_back(r);
    endfunction

    // Advance the scan by one accepted item and queue what it should produce.
    function void note_item(in_item_t it);
      logic [7:0] c;
      c = it.char_code;
      if (it.line_end) begin
        if (!verdict_given)
          queue_result(KIND_REJECT, 8'h00, 1'b0);
        restart_line();
        return;
      end
      case (phase)
        SCAN_START: begin
          if (blank_char(c)) begin
            phase = SCAN_LEAD;
          end else if ((c == CH_UNDER || alpha_char(c)) && !incbin_mode) begin
            take_letter(c);
            phase = SCAN_WORD;
          end else begin
            phase = SCAN_DONE;
          end
        end
        SCAN_LEAD: begin
          if (c == CH_UNDER || alpha_char(c)) begin
            take_letter(c);
            phase = SCAN_WORD;
          end else if (!blank_char(c)) begin
            phase = SCAN_DONE;
          end
        end
        SCAN_WORD: begin
          if (alpha_char(c) || num_char(c)) begin
            take_letter(c);
          end else if (blank_char(c)) begin
            if (include_ok && word_len == INC_LEN) begin
              incbin_ok = 1'b0;
              phase     = SCAN_GAP;
            end else if (incbin_mode && incbin_ok && word_len == BIN_LEN) begin
              include_ok = 1'b0;
              phase      = SCAN_GAP;
            end else begin
              phase = SCAN_DONE;
            end
          end else begin
            phase = SCAN_DONE;
          end
        end
        SCAN_GAP: begin
          if (c == CH_QUOTE)
            phase = SCAN_NAME;
          else if (!blank_char(c))
            phase = SCAN_DONE;
        end
        SCAN_NAME: begin
          if (c == CH_QUOTE) begin
            queue_result(KIND_FOUND, 8'h00, include_ok);
            verdict_given = 1'b1;
            phase         = SCAN_DONE;
          end else begin
            queue_result(KIND_NAME, c, 1'b0);
          end
        end
        default: phase = SCAN_DONE;
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_item(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d byte %02h flag %0b",
                         got.kind, got.name_byte, got.parse_flag));
        return;
      end
      want = pending_results.pop_front();
      case (want.kind)
        KIND_NAME:  names_seen++;
        KIND_FOUND: found_seen++;
        default:    rejects_seen++;
      endcase
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
      if (got.name_byte !== want.name_byte)
        report($sformatf("name_byte %02h, wanted %02h", got.name_byte, want.name_byte));
      if (got.parse_flag !== want.parse_flag)
        report($sformatf("parse_flag %0b, wanted %0b", got.parse_flag, want.parse_flag));
    endtask
  endclass

endpackage

/* tb/tb_top.sv */
// Testbench top: feeds source lines to the include directive recogniser and checks every result.
`timescale 1ns / 1ps

module tb_top;
  import idr_pkg::*;
  import idr_check_pkg::*;

  localparam int unsigned QUIET_LIMIT     = 2000;  // cycles with no handshake at all
  localparam int unsigned HOLD_CYCLES     = 80;    // receiver hold-off under pressure
  localparam int unsigned ITEMS_PER_PHASE = 340;
  localparam int unsigned IDLE_PERCENT    = 19;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  directive_scoreboard sb = new();

  // Shared between the sender, the receiver, the main sequence and the watchdog
  bit          steady       = 1'b0;  // no idling on either side while set
  bit          hold_request = 1'b0;  // ask the receiver for one long hold-off
  int unsigned items_sent   = 0;
  int unsigned lines_sent   = 0;
  int unsigned mode_writes  = 0;
  int unsigned quiet_cycles = 0;

  include_directive_recognizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Character helpers for building lines
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick_blank();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  // Letter or digit, lower case
  function automatic logic [7:0] pick_word_char();
    if ($urandom_range(3) != 0)
      return 8'h61 + 8'($urandom_range(25));
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  // Any byte, leaning on the ones that steer the scan
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return CH_QUOTE;
      3:       return pick_blank();
      4:       return CH_UNDER;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Turn a lower-case letter to upper case at random; leave anything else alone.
  function automatic logic [7:0] mix_case(logic [7:0] c);
    if (c inside {[8'h61:8'h7A]} && $urandom_range(1))
      return c & 8'hDF;
    return c;
  endfunction

  // Build one random line. Most lines are directives with random content and
  // spacing; the rest carry a damaged keyword or are plain noise.
  function automatic void build_line(input bit incbin_mode, ref logic [7:0] txt[$]);
    logic [7:0]  wq[$];
    string       word;
    int unsigned shape;
    int unsigned n;
    txt.delete();
    shape = $urandom_range(99);
    if (shape < 12) begin
      n = $urandom_range(10);
      repeat (n) txt.push_back($urandom_range(1) ? pick_byte() : mix_case(pick_word_char()));
      return;
    end
    // leading blanks: mode 1 needs at least one, so only seldom leave them out
    n = $urandom_range(3);
    if (incbin_mode && n == 0 && $urandom_range(4) != 0)
      n = 1;
    repeat (n) txt.push_back(pick_blank());
    if (incbin_mode ? $urandom_range(1) : ($urandom_range(4) != 0))
      word = "include";
    else
      word = "incbin";
    for (int i = 0; i < word.len(); i++)
      wq.push_back(word[i]);
    // damage the keyword: shorten, swap a letter, lengthen (past saturation too)
    // or put an underscore in front
    if (shape < 30) begin
      case ($urandom_range(3))
        0: void'(wq.pop_back());
        1: wq[$urandom_range(wq.size() - 1)] = pick_word_char();
        2: repeat ($urandom_range(1, 12)) wq.push_back(pick_word_char());
        default: wq.push_front(CH_UNDER);
      endcase
    end
    foreach (wq[i])
      txt.push_back(mix_case(wq[i]));
    n = $urandom_range(1, 3);
    if ($urandom_range(19) == 0)
      n = 0;
    repeat (n) txt.push_back(pick_blank());
    txt.push_back(($urandom_range(19) == 0) ? pick_byte() : CH_QUOTE);
    n = $urandom_range(6);
    repeat (n) txt.push_back(($urandom_range(4) == 0) ? pick_blank() : pick_byte());
    if ($urandom_range(9) != 0)
      txt.push_back(CH_QUOTE);
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 4)) txt.push_back(pick_byte());
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one item and hold it until the block takes it. The valid is left
  // high on return so that a back-to-back item needs no second assignment.
  task automatic offer_item(in_item_t it);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic offer_char(logic [7:0] c);
    in_item_t it;
    it.char_code = c;
    it.line_end  = 1'b0;
    offer_item(it);
  endtask

  // Close the line; the character field is junk and must be ignored.
  task automatic end_line();
    in_item_t it;
    it.char_code = 8'($urandom_range(255));
    it.line_end  = 1'b1;
    offer_item(it);
    lines_sent++;
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++)
      offer_char(s[i]);
  endtask

  task automatic send_line(logic [7:0] txt[$]);
    foreach (txt[i])
      offer_char(txt[i]);
    end_line();
  endtask

  // Drop the valid, wait for every queued result, then give a line that
  // caused no result time to leave the block before touching the register.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_mode(m);
    mode_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: check each accepted result, then pick the next ready. A hold-off
  // request is served here and counted down locally, so the sender keeps
  // pushing while results back up and the input stalls.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_item(out_item);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog: end the run if no channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, sb.pending_results.size());
      $display("include_directive_recognizer regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0]  txt[$];
    bit          mode;
    bit          pressed;
    int unsigned start;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    pressed   = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines, mode 0: empty and blank-only lines, empty name, odd
    // bytes and blanks in the name with text after the closing quote, an
    // unterminated name, incbin where only include is allowed, a keyword one
    // letter too long and a word that starts with an underscore.
    write_mode(1'b0);
    end_line();
    send_str("  \t ");
    end_line();
    send_str("include \"\"");
    end_line();
    send_str("\tInClUdE \t\"a b");
    offer_char(8'h00);
    offer_char(8'hFF);
    send_str("\"x\"");
    end_line();
    send_str("include \"ab");
    end_line();
    send_str("incbin \"x\"");
    end_line();
    send_str("includes \"x\"");
    end_line();
    send_str("_9 \"x\"");
    end_line();
    settle();

    // Directed lines, mode 1: missing leading blank, incbin and include found,
    // a short keyword and a name glued to the keyword.
    write_mode(1'b1);
    send_str("include \"q\"");
    end_line();
    send_str(" incbin \"bin\"");
    end_line();
    send_str("\tINCLUDE \"i\"");
    end_line();
    send_str(" inc \"x\"");
    end_line();
    send_str(" include\"x\"");
    end_line();
    settle();

    // Random phases, alternating the mode. The third runs with no idling at
    // all; in the fourth the receiver holds off once while items keep coming.
    for (int p = 0; p < 4; p++) begin
      mode = (p % 2 == 0);
      write_mode(mode);
      steady = (p == 2);
      start  = items_sent;
      while (items_sent - start < ITEMS_PER_PHASE) begin
        if (p == 3 && !pressed && items_sent - start > 100) begin
          hold_request = 1'b1;
          pressed      = 1'b1;
        end
        build_line(mode, txt);
        send_line(txt);
      end
      settle();
    end
    steady = 1'b0;

    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));

    $display("covered %0d items over %0d lines in both syntax modes, %0d mode writes",
             items_sent, lines_sent, mode_writes);
    $display("checked %0d name bytes, %0d directives found, %0d lines rejected; %0d errors",
             sb.names_seen, sb.found_seen, sb.rejects_seen, sb.errors);
    if (sb.errors == 0)
      $display("include_directive_recognizer regression: pass");
    else
      $display("include_directive_recognizer regression: fail");
    $finish;
  end

endmodule
